// ===== design/dltq_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and microcode table of the delta list timer queue
package dltq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 8;
  localparam int MS_W   = 16;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // microprogram addresses
  typedef enum logic [2:0] {
    ST_FETCH    = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_CHKFULL  = 3'd2,
    ST_WALK     = 3'd3,
    ST_PLACE    = 3'd4,
    ST_EXPIRE   = 3'd5,
    ST_DROP     = 3'd6
  } step_t;

  // sequencing kinds
  typedef enum logic [1:0] {
    SEQ_WAIT_IN = 2'd0,  // hold until an input item is taken, then fall through
    SEQ_BRANCH  = 2'd1,  // jump on condition, else fall through
    SEQ_LOOP    = 2'd2,  // jump on condition, else do the action and repeat
    SEQ_EMIT    = 2'd3   // do the action once the result register is free, then jump
  } seq_t;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_EXP  = 2'd1,
    COND_FULL = 2'd2,
    COND_STOP = 2'd3
  } cond_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_LATCH = 3'd1,
    ACT_SUB   = 3'd2,
    ACT_PLACE = 3'd3,
    ACT_POP   = 3'd4,
    ACT_DROP  = 3'd5
  } act_t;

  typedef struct packed {
    seq_t  seq;
    cond_t cond;
    step_t target;
    act_t  act;
  } cw_t;

  // sequencer to datapath
  typedef struct packed {
    act_t act;
    logic fire;
    logic take;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_exp;
    logic full;
    logic stop;
  } flags_t;

  function automatic cw_t ucode(step_t pc);
    cw_t cw;
    unique case (pc)
      ST_FETCH:    cw = '{SEQ_WAIT_IN, COND_NONE, ST_FETCH,  ACT_LATCH};
      ST_DISPATCH: cw = '{SEQ_BRANCH,  COND_EXP,  ST_EXPIRE, ACT_NONE};
      ST_CHKFULL:  cw = '{SEQ_BRANCH,  COND_FULL, ST_DROP,   ACT_NONE};
      ST_WALK:     cw = '{SEQ_LOOP,    COND_STOP, ST_PLACE,  ACT_SUB};
      ST_PLACE:    cw = '{SEQ_EMIT,    COND_NONE, ST_FETCH,  ACT_PLACE};
      ST_EXPIRE:   cw = '{SEQ_EMIT,    COND_NONE, ST_FETCH,  ACT_POP};
      ST_DROP:     cw = '{SEQ_EMIT,    COND_NONE, ST_FETCH,  ACT_DROP};
      default:     cw = '{SEQ_BRANCH,  COND_NONE, ST_FETCH,  ACT_NONE};
    endcase
    return cw;
  endfunction

endpackage

// ===== design/dltq_ifs.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces

interface dltq_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [dltq_pkg::ID_W-1:0]    req_id;
  logic [dltq_pkg::MS_W-1:0]    duration_ms;
  logic [dltq_pkg::MS_W-1:0]    elapsed_ms;
  modport source (output valid, cmd, req_id, duration_ms, elapsed_ms, input ready);
  modport sink   (input valid, cmd, req_id, duration_ms, elapsed_ms, output ready);
endinterface

interface dltq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         notify_valid;
  logic [dltq_pkg::ID_W-1:0]    notify_id;
  logic                         load_valid;
  logic [dltq_pkg::MS_W-1:0]    load_ms;
  logic [dltq_pkg::STAT_W-1:0]  status;
  modport source (output valid, notify_valid, notify_id, load_valid, load_ms, status,
                  input ready);
  modport sink   (input valid, notify_valid, notify_id, load_valid, load_ms, status,
                  output ready);
endinterface

// ===== design/dltq_sequencer.sv =====
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom and branch logic
module dltq_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  dltq_pkg::flags_t flags,
  output dltq_pkg::ctrl_t  ctrl
);

  dltq_pkg::step_t pc;
  dltq_pkg::step_t pc_next;
  dltq_pkg::cw_t   cw;
  logic            cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dltq_pkg::ST_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    cw = dltq_pkg::ucode(pc);
    unique case (cw.cond)
      dltq_pkg::COND_NONE: cond_true = 1'b0;
      dltq_pkg::COND_EXP:  cond_true = flags.is_exp;
      dltq_pkg::COND_FULL: cond_true = flags.full;
      dltq_pkg::COND_STOP: cond_true = flags.stop;
      default:             cond_true = 1'b0;
    endcase

    ctrl.act  = cw.act;
    ctrl.fire = 1'b0;
    ctrl.take = 1'b0;
    pc_next   = pc;
    unique case (cw.seq)
      dltq_pkg::SEQ_WAIT_IN: begin
        ctrl.take = 1'b1;
        ctrl.fire = flags.in_valid;
        if (flags.in_valid) begin
          pc_next = dltq_pkg::step_t'(pc + 3'd1);
        end
      end
      dltq_pkg::SEQ_BRANCH: begin
        pc_next = cond_true ? cw.target : dltq_pkg::step_t'(pc + 3'd1);
      end
      dltq_pkg::SEQ_LOOP: begin
        if (cond_true) begin
          pc_next = cw.target;
        end else begin
          ctrl.fire = 1'b1;
        end
      end
      dltq_pkg::SEQ_EMIT: begin
        ctrl.fire = flags.out_free;
        if (flags.out_free) begin
          pc_next = cw.target;
        end
      end
      default: pc_next = dltq_pkg::ST_FETCH;
    endcase
  end

endmodule

// ===== design/dltq_datapath.sv =====
`timescale 1ns / 1ps
// datapath: entry store, walk registers and result register
module dltq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dltq_pkg::ctrl_t   ctrl,
  output dltq_pkg::flags_t  flags,
  dltq_req_if.sink          req,
  dltq_rsp_if.source        rsp
);

  logic [dltq_pkg::ID_W-1:0]  ids    [dltq_pkg::DEPTH];
  logic [dltq_pkg::MS_W-1:0]  deltas [dltq_pkg::DEPTH];
  logic [dltq_pkg::CNT_W-1:0] count;

  logic                       cmd;
  logic [dltq_pkg::ID_W-1:0]  new_id;
  logic [dltq_pkg::MS_W-1:0]  rem;
  logic [dltq_pkg::MS_W-1:0]  elapsed;
  logic [dltq_pkg::CNT_W-1:0] pos;

  logic [dltq_pkg::MS_W-1:0]  raw;
  logic [dltq_pkg::MS_W-1:0]  d;
  logic                       at_head;
  logic                       at_end;
  logic                       out_free;

  // head delta is reduced by time already run on the countdown, floored at zero
  always_comb begin
    raw     = deltas[pos[dltq_pkg::IDX_W-1:0]];
    at_head = (pos == '0);
    at_end  = (pos == count);
    if (at_head) begin
      d = (raw > elapsed) ? raw - elapsed : '0;
    end else begin
      d = raw;
    end
  end

  assign out_free       = !rsp.valid || rsp.ready;
  assign req.ready      = ctrl.take;
  assign flags.in_valid = req.valid;
  assign flags.out_free = out_free;
  assign flags.is_exp   = cmd;
  assign flags.full     = (count == dltq_pkg::CNT_W'(dltq_pkg::DEPTH));
  assign flags.stop     = at_end || (rem < d);

  // walk registers
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.act == dltq_pkg::ACT_LATCH) begin
      cmd     <= req.cmd;
      new_id  <= req.req_id;
      rem     <= req.duration_ms;
      elapsed <= req.elapsed_ms;
      pos     <= '0;
    end else if (ctrl.fire && ctrl.act == dltq_pkg::ACT_SUB) begin
      rem <= rem - d;
      pos <= pos + 1'b1;
    end
  end

  // entry store: shift up behind the insert point, shift down on pop
  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.act == dltq_pkg::ACT_PLACE) begin
      if (at_head) begin
        ids[0]    <= new_id;
        deltas[0] <= rem;
      end
      for (int k = 1; k < dltq_pkg::DEPTH; k++) begin
        if (dltq_pkg::CNT_W'(k) > pos) begin
          ids[k]    <= ids[k-1];
          deltas[k] <= (dltq_pkg::CNT_W'(k) == pos + 1'b1) ? d - rem : deltas[k-1];
        end else if (dltq_pkg::CNT_W'(k) == pos) begin
          ids[k]    <= new_id;
          deltas[k] <= rem;
        end
      end
    end else if (ctrl.fire && ctrl.act == dltq_pkg::ACT_POP && count != '0) begin
      for (int k = 0; k < dltq_pkg::DEPTH - 1; k++) begin
        ids[k]    <= ids[k+1];
        deltas[k] <= deltas[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.fire && ctrl.act == dltq_pkg::ACT_PLACE) begin
      count <= count + 1'b1;
    end else if (ctrl.fire && ctrl.act == dltq_pkg::ACT_POP && count != '0) begin
      count <= count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctrl.fire && (ctrl.act == dltq_pkg::ACT_PLACE ||
                               ctrl.act == dltq_pkg::ACT_POP ||
                               ctrl.act == dltq_pkg::ACT_DROP)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.act)
        dltq_pkg::ACT_PLACE: begin
          rsp.notify_valid <= 1'b0;
          rsp.notify_id    <= '0;
          rsp.load_valid   <= at_head;
          rsp.load_ms      <= at_head ? rem : '0;
          rsp.status       <= dltq_pkg::STAT_OK;
        end
        dltq_pkg::ACT_POP: begin
          if (count == '0) begin
            rsp.notify_valid <= 1'b0;
            rsp.notify_id    <= '0;
            rsp.load_valid   <= 1'b0;
            rsp.load_ms      <= '0;
            rsp.status       <= dltq_pkg::STAT_EMPTY;
          end else begin
            rsp.notify_valid <= 1'b1;
            rsp.notify_id    <= ids[0];
            rsp.load_valid   <= (count > dltq_pkg::CNT_W'(1));
            rsp.load_ms      <= (count > dltq_pkg::CNT_W'(1)) ?
                                deltas[dltq_pkg::IDX_W'(1)] : '0;
            rsp.status       <= dltq_pkg::STAT_OK;
          end
        end
        dltq_pkg::ACT_DROP: begin
          rsp.notify_valid <= 1'b0;
          rsp.notify_id    <= '0;
          rsp.load_valid   <= 1'b0;
          rsp.load_ms      <= '0;
          rsp.status       <= dltq_pkg::STAT_FULL;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/delta_list_timer_queue_core.sv =====
`timescale 1ns / 1ps
// top level of the delta list timer queue
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   cmd, req_id, duration_ms, elapsed_ms
//  rsp      out  valid/ready   notify_valid, notify_id, load_valid, load_ms, status
//
// one item at a time; an item is taken, then dispatched: expire pops the head; a
// start is dropped if the queue is full, else walks past 0..15 entries and is
// placed; each walk step does one subtract and compare against a stored delta
// synchronous reset empties the queue; stored entries are not cleared
// a result waiting on rsp does not stop the next item from being taken, only
// the next result write waits for the register to drain
module delta_list_timer_queue_core (
  input logic         clk,
  input logic         rst,
  dltq_req_if.sink    req,
  dltq_rsp_if.source  rsp
);

  // control word fields decoded by the sequencer each step
  dltq_pkg::ctrl_t  ctrl;
  // branch conditions and handshake state seen by the sequencer
  dltq_pkg::flags_t flags;

  // step counter and microcode rom
  dltq_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // entry store, walk arithmetic and result register
  dltq_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .flags (flags),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

// ===== design/dltq_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the timer queue, bound to the top level
module dltq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          notify_valid,
  input logic [dltq_pkg::ID_W-1:0]     notify_id,
  input logic                          load_valid,
  input logic [dltq_pkg::MS_W-1:0]     load_ms,
  input logic [dltq_pkg::STAT_W-1:0]   status
);

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending after reset");

  // an item is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken back to back");

  // error results carry no notify and no load
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != dltq_pkg::STAT_OK |-> !notify_valid && !load_valid)
    else $error("error result with notify or load");

  // unused fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (notify_valid || notify_id == '0) && (load_valid || load_ms == '0))
    else $error("field set without its valid");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(notify_id) && $stable(load_ms)
      && $stable(status) && $stable(notify_valid) && $stable(load_valid))
    else $error("stalled result changed");

endmodule

bind delta_list_timer_queue_core dltq_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .notify_valid (rsp.notify_valid),
  .notify_id    (rsp.notify_id),
  .load_valid   (rsp.load_valid),
  .load_ms      (rsp.load_ms),
  .status       (rsp.status)
);
